/* design/lfr_pkg.sv */
// lfr_pkg: shared codes, register map and reset values of the line follower
// recovery block; used by the top level and its checker
// no dependencies
package lfr_pkg;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_BASE_SPEED_A      = 3'd0;
    localparam logic [2:0] REG_BASE_SPEED_B      = 3'd1;
    localparam logic [2:0] REG_TURN_SPEED        = 3'd2;
    localparam logic [2:0] REG_SLIGHT_TURN_SPEED = 3'd3;
    localparam logic [2:0] REG_SEARCH_SPEED      = 3'd4;
    localparam logic [2:0] REG_SWEEP_TICKS       = 3'd5;
    localparam logic [2:0] REG_REVERSE_TICKS     = 3'd6;
    localparam logic [2:0] REG_MAX_SWEEPS        = 3'd7;

    localparam int unsigned PADDR_W = 5;

    // register reset values
    localparam logic [7:0]  RST_BASE_SPEED_A      = 8'd28;
    localparam logic [7:0]  RST_BASE_SPEED_B      = 8'd29;
    localparam logic [7:0]  RST_TURN_SPEED        = 8'd25;
    localparam logic [7:0]  RST_SLIGHT_TURN_SPEED = 8'd15;
    localparam logic [7:0]  RST_SEARCH_SPEED      = 8'd24;
    localparam logic [15:0] RST_SWEEP_TICKS       = 16'd150;
    localparam logic [15:0] RST_REVERSE_TICKS     = 16'd2500;
    localparam logic [3:0]  RST_MAX_SWEEPS        = 4'd3;

    // fixed duties on a crossing
    localparam logic [7:0] CROSS_DUTY_A = 8'd28;
    localparam logic [7:0] CROSS_DUTY_B = 8'd31;

    // drive directions
    localparam logic [2:0] DIR_FORWARD  = 3'd0;
    localparam logic [2:0] DIR_BACKWARD = 3'd1;
    localparam logic [2:0] DIR_LEFT     = 3'd2;
    localparam logic [2:0] DIR_RIGHT    = 3'd3;
    localparam logic [2:0] DIR_STOP     = 3'd4;

    // recovery modes
    localparam logic [1:0] MODE_FOLLOW  = 2'd0;
    localparam logic [1:0] MODE_RIGHT   = 2'd1;
    localparam logic [1:0] MODE_LEFT    = 2'd2;
    localparam logic [1:0] MODE_REVERSE = 2'd3;

    // sensor patterns, left centre right
    localparam logic [2:0] PAT_NONE   = 3'b000;
    localparam logic [2:0] PAT_R      = 3'b001;
    localparam logic [2:0] PAT_C      = 3'b010;
    localparam logic [2:0] PAT_CR     = 3'b011;
    localparam logic [2:0] PAT_L      = 3'b100;
    localparam logic [2:0] PAT_LR     = 3'b101;
    localparam logic [2:0] PAT_LC     = 3'b110;
    localparam logic [2:0] PAT_ALL    = 3'b111;

    // output tdata field positions
    localparam int unsigned OUT_DIR_LSB   = 0;
    localparam int unsigned OUT_DUTYA_LSB = 3;
    localparam int unsigned OUT_DUTYB_LSB = 11;
    localparam int unsigned OUT_PHASE_LSB = 19;

endpackage

/* design/line_follower_recovery_fsm.sv */
// line_follower_recovery_fsm: steering and timed line recovery from three
// line sensors; depends on lfr_pkg
//
// usage:
//   s_* stream: one beat per sensor sample, tdata = {now_ticks, right,
//   centre, left}. m_* stream: one beat per sample with the drive
//   direction, both motor duties and the recovery phase after the step.
//   apb port: eight registers at byte address 4*index, pready always high.
// pipeline:
//   a sample is held in an input register, the step is evaluated in
//   combinational logic (one 32-bit subtract and two compares on the tick count)
//   and the result lands in the output register, which drives m_tvalid;
//   one sample per cycle sustained while m_tready stays high.
// reset:
//   registers return to their defaults, the mode goes to following and
//   both stages empty.
// stall:
//   while m_tready is low the result holds; one more sample is taken into
//   the input register, then s_tready drops until the result is taken.
module line_follower_recovery_fsm
(
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [lfr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // sense_left, sense_center, sense_right, now_ticks[31:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // drive_dir[2:0], duty_a[7:0], duty_b[7:0], recovery_phase[1:0]
);

    // configuration registers
    logic [7:0]  base_speed_a_reg;
    logic [7:0]  base_speed_b_reg;
    logic [7:0]  turn_speed_reg;
    logic [7:0]  slight_turn_speed_reg;
    logic [7:0]  search_speed_reg;
    logic [15:0] sweep_ticks_reg;
    logic [15:0] reverse_ticks_reg;
    logic [3:0]  max_sweeps_reg;

    logic        cfg_write;
    logic [2:0]  cfg_index;

    // step state
    logic [1:0]  mode_reg,        mode_next;
    logic [31:0] phase_start_reg, phase_start_next;
    logic [3:0]  sweeps_done_reg, sweeps_done_next;

    // input stage
    logic        in_valid_reg;
    logic [2:0]  in_pat_reg;
    logic [31:0] in_now_reg;

    // output stage
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_dir_reg,   out_dir_next;
    logic [7:0]  out_duty_a_reg, out_duty_a_next;
    logic [7:0]  out_duty_b_reg, out_duty_b_next;
    logic [1:0]  out_phase_reg;

    logic        s_accept;
    logic        advance;

    // recovery helpers
    logic        from_follow;
    logic [1:0]  cur_mode;
    logic [31:0] start_eff;
    logic [3:0]  sweeps_eff;
    logic [3:0]  sweeps_inc;
    logic [31:0] elapsed;
    logic        sweep_over;
    logic        reverse_over;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_speed_a_reg      <= lfr_pkg::RST_BASE_SPEED_A;
            base_speed_b_reg      <= lfr_pkg::RST_BASE_SPEED_B;
            turn_speed_reg        <= lfr_pkg::RST_TURN_SPEED;
            slight_turn_speed_reg <= lfr_pkg::RST_SLIGHT_TURN_SPEED;
            search_speed_reg      <= lfr_pkg::RST_SEARCH_SPEED;
            sweep_ticks_reg       <= lfr_pkg::RST_SWEEP_TICKS;
            reverse_ticks_reg     <= lfr_pkg::RST_REVERSE_TICKS;
            max_sweeps_reg        <= lfr_pkg::RST_MAX_SWEEPS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lfr_pkg::REG_BASE_SPEED_A:      base_speed_a_reg      <= pwdata[7:0];
                lfr_pkg::REG_BASE_SPEED_B:      base_speed_b_reg      <= pwdata[7:0];
                lfr_pkg::REG_TURN_SPEED:        turn_speed_reg        <= pwdata[7:0];
                lfr_pkg::REG_SLIGHT_TURN_SPEED: slight_turn_speed_reg <= pwdata[7:0];
                lfr_pkg::REG_SEARCH_SPEED:      search_speed_reg      <= pwdata[7:0];
                lfr_pkg::REG_SWEEP_TICKS:       sweep_ticks_reg       <= pwdata[15:0];
                lfr_pkg::REG_REVERSE_TICKS:     reverse_ticks_reg     <= pwdata[15:0];
                lfr_pkg::REG_MAX_SWEEPS:        max_sweeps_reg        <= pwdata[3:0];
                default:                        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            lfr_pkg::REG_BASE_SPEED_A:      prdata = {24'd0, base_speed_a_reg};
            lfr_pkg::REG_BASE_SPEED_B:      prdata = {24'd0, base_speed_b_reg};
            lfr_pkg::REG_TURN_SPEED:        prdata = {24'd0, turn_speed_reg};
            lfr_pkg::REG_SLIGHT_TURN_SPEED: prdata = {24'd0, slight_turn_speed_reg};
            lfr_pkg::REG_SEARCH_SPEED:      prdata = {24'd0, search_speed_reg};
            lfr_pkg::REG_SWEEP_TICKS:       prdata = {16'd0, sweep_ticks_reg};
            lfr_pkg::REG_REVERSE_TICKS:     prdata = {16'd0, reverse_ticks_reg};
            lfr_pkg::REG_MAX_SWEEPS:        prdata = {28'd0, max_sweeps_reg};
            default:                        prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // sample payload, pattern packed left centre right
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_pat_reg <= {s_tdata[0], s_tdata[1], s_tdata[2]};
            in_now_reg <= s_tdata[34:3];
        end
    end

    // ---------------- step logic ----------------
    // losing the line while following starts a fresh right sweep
    assign from_follow  = (mode_reg == lfr_pkg::MODE_FOLLOW);
    assign cur_mode     = from_follow ? lfr_pkg::MODE_RIGHT : mode_reg;
    assign start_eff    = from_follow ? in_now_reg : phase_start_reg;
    assign sweeps_eff   = from_follow ? 4'd0 : sweeps_done_reg;
    assign sweeps_inc   = sweeps_eff + 4'd1;
    assign elapsed      = in_now_reg - start_eff;
    assign sweep_over   = (elapsed >= {16'd0, sweep_ticks_reg});
    assign reverse_over = (elapsed >= {16'd0, reverse_ticks_reg});

    always_comb
    begin
        mode_next        = mode_reg;
        phase_start_next = phase_start_reg;
        sweeps_done_next = sweeps_done_reg;
        out_dir_next     = lfr_pkg::DIR_FORWARD;
        out_duty_a_next  = 8'd0;
        out_duty_b_next  = 8'd0;
        unique case (in_pat_reg)
            lfr_pkg::PAT_C:
            begin
                out_duty_a_next = base_speed_a_reg;
                out_duty_b_next = base_speed_b_reg;
            end
            lfr_pkg::PAT_ALL:
            begin
                out_duty_a_next = lfr_pkg::CROSS_DUTY_A;
                out_duty_b_next = lfr_pkg::CROSS_DUTY_B;
            end
            lfr_pkg::PAT_LR:
            begin
                out_dir_next    = lfr_pkg::DIR_LEFT;
                out_duty_a_next = slight_turn_speed_reg;
                out_duty_b_next = slight_turn_speed_reg;
            end
            lfr_pkg::PAT_L:
            begin
                mode_next       = lfr_pkg::MODE_FOLLOW;
                out_dir_next    = lfr_pkg::DIR_LEFT;
                out_duty_a_next = turn_speed_reg;
                out_duty_b_next = turn_speed_reg;
            end
            lfr_pkg::PAT_LC:
            begin
                mode_next       = lfr_pkg::MODE_FOLLOW;
                out_dir_next    = lfr_pkg::DIR_LEFT;
                out_duty_a_next = slight_turn_speed_reg;
                out_duty_b_next = slight_turn_speed_reg;
            end
            lfr_pkg::PAT_R:
            begin
                mode_next       = lfr_pkg::MODE_FOLLOW;
                out_dir_next    = lfr_pkg::DIR_RIGHT;
                out_duty_a_next = turn_speed_reg;
                out_duty_b_next = turn_speed_reg;
            end
            lfr_pkg::PAT_CR:
            begin
                mode_next       = lfr_pkg::MODE_FOLLOW;
                out_dir_next    = lfr_pkg::DIR_RIGHT;
                out_duty_a_next = slight_turn_speed_reg;
                out_duty_b_next = slight_turn_speed_reg;
            end
            default:
            begin
                // no line seen: recovery sequence
                mode_next        = cur_mode;
                phase_start_next = start_eff;
                sweeps_done_next = sweeps_eff;
                unique case (cur_mode)
                    lfr_pkg::MODE_RIGHT:
                    begin
                        out_dir_next    = lfr_pkg::DIR_RIGHT;
                        out_duty_b_next = search_speed_reg;
                        if (sweep_over)
                        begin
                            mode_next        = lfr_pkg::MODE_LEFT;
                            phase_start_next = in_now_reg;
                        end
                    end
                    lfr_pkg::MODE_LEFT:
                    begin
                        out_dir_next    = lfr_pkg::DIR_LEFT;
                        out_duty_a_next = search_speed_reg;
                        if (sweep_over)
                        begin
                            sweeps_done_next = sweeps_inc;
                            mode_next        = (sweeps_inc < max_sweeps_reg) ?
                                               lfr_pkg::MODE_RIGHT : lfr_pkg::MODE_REVERSE;
                            phase_start_next = in_now_reg;
                        end
                    end
                    default:
                    begin
                        // reverse, then stop once the window is used up
                        out_dir_next    = reverse_over ? lfr_pkg::DIR_STOP
                                                       : lfr_pkg::DIR_BACKWARD;
                        out_duty_a_next = search_speed_reg;
                        out_duty_b_next = search_speed_reg;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= lfr_pkg::MODE_FOLLOW;
            phase_start_reg <= 32'd0;
            sweeps_done_reg <= 4'd0;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            phase_start_reg <= phase_start_next;
            sweeps_done_reg <= sweeps_done_next;
        end
    end

    // ---------------- output stage ----------------
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_dir_reg    <= out_dir_next;
            out_duty_a_reg <= out_duty_a_next;
            out_duty_b_reg <= out_duty_b_next;
            out_phase_reg  <= mode_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_phase_reg, out_duty_b_reg, out_duty_a_reg, out_dir_reg};

endmodule

/* design/lfr_checker.sv */
// lfr_checker: port-level assertions for line_follower_recovery_fsm and the
// bind that attaches them; depends on lfr_pkg
module lfr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    logic [2:0] dir;
    logic [1:0] phase;

    assign dir   = m_tdata[lfr_pkg::OUT_DIR_LSB +: 3];
    assign phase = m_tdata[lfr_pkg::OUT_PHASE_LSB +: 2];

    // offered sample beat holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("sample beat changed while stalled");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // empty output stage never back-pressures the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // direction code is always a legal one
    a_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (dir <= lfr_pkg::DIR_STOP))
        else $error("illegal drive direction");

    // stop and backward only come from the reverse phase
    a_stop_in_reverse: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (dir == lfr_pkg::DIR_STOP || dir == lfr_pkg::DIR_BACKWARD)
        |-> phase == lfr_pkg::MODE_REVERSE)
        else $error("stop or backward outside reverse phase");

endmodule

bind line_follower_recovery_fsm lfr_checker u_lfr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/sv/line_follower_recovery_fsm_tb.sv */
// line_follower_recovery_fsm_tb: self-checking bench for the line follower with timed recovery
// drives sensor beats and apb writes, predicts every result beat and compares field by field
// depends on lfr_pkg and line_follower_recovery_fsm
module line_follower_recovery_fsm_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned PHASE_ITEMS    = 240;

    typedef struct packed {
        logic [31:0] now_ticks;
        logic        sense_right;
        logic        sense_center;
        logic        sense_left;
    } lfr_sample_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] duty_b;
        logic [7:0] duty_a;
        logic [2:0] dir;
    } lfr_drive_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [lfr_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // sense_left, sense_center, sense_right, now_ticks[31:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // drive_dir[2:0], duty_a[7:0], duty_b[7:0], recovery_phase[1:0]

    // configuration copy used by the predictor and the stimulus
    logic [7:0]  cfg_base_a = lfr_pkg::RST_BASE_SPEED_A;
    logic [7:0]  cfg_base_b = lfr_pkg::RST_BASE_SPEED_B;
    logic [7:0]  cfg_turn = lfr_pkg::RST_TURN_SPEED;
    logic [7:0]  cfg_slight = lfr_pkg::RST_SLIGHT_TURN_SPEED;
    logic [7:0]  cfg_search = lfr_pkg::RST_SEARCH_SPEED;
    logic [15:0] cfg_sweep_ticks = lfr_pkg::RST_SWEEP_TICKS;
    logic [15:0] cfg_reverse_ticks = lfr_pkg::RST_REVERSE_TICKS;
    logic [3:0]  cfg_max_sweeps = lfr_pkg::RST_MAX_SWEEPS;

    // recovery state of the predictor
    logic [1:0]  rec_mode = lfr_pkg::MODE_FOLLOW;
    logic [31:0] rec_start = '0;
    logic [3:0]  rec_pairs = '0;

    lfr_sample_t sample_q[$];
    lfr_drive_t  drive_q[$];
    logic [31:0] tick_now = '0;
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;
    int          src_wait = 0;
    int          src_calm = 0;
    int          snk_wait = 0;
    int          snk_calm = 0;
    int          hold_left = 0;
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;

    line_follower_recovery_fsm u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // steering and recovery step, updates the predictor state
    function automatic lfr_drive_t next_drive(lfr_sample_t s);
        lfr_drive_t  res;
        logic [2:0]  pat;
        logic [31:0] elapsed;
        pat = {s.sense_left, s.sense_center, s.sense_right};
        res = '0;
        res.dir = lfr_pkg::DIR_FORWARD;
        case (pat)
            lfr_pkg::PAT_C:
            begin
                res.duty_a = cfg_base_a;
                res.duty_b = cfg_base_b;
            end
            lfr_pkg::PAT_ALL:
            begin
                res.duty_a = lfr_pkg::CROSS_DUTY_A;
                res.duty_b = lfr_pkg::CROSS_DUTY_B;
            end
            lfr_pkg::PAT_LR:
            begin
                res.dir = lfr_pkg::DIR_LEFT;
                res.duty_a = cfg_slight;
                res.duty_b = cfg_slight;
            end
            lfr_pkg::PAT_L:
            begin
                rec_mode = lfr_pkg::MODE_FOLLOW;
                res.dir = lfr_pkg::DIR_LEFT;
                res.duty_a = cfg_turn;
                res.duty_b = cfg_turn;
            end
            lfr_pkg::PAT_LC:
            begin
                rec_mode = lfr_pkg::MODE_FOLLOW;
                res.dir = lfr_pkg::DIR_LEFT;
                res.duty_a = cfg_slight;
                res.duty_b = cfg_slight;
            end
            lfr_pkg::PAT_R:
            begin
                rec_mode = lfr_pkg::MODE_FOLLOW;
                res.dir = lfr_pkg::DIR_RIGHT;
                res.duty_a = cfg_turn;
                res.duty_b = cfg_turn;
            end
            lfr_pkg::PAT_CR:
            begin
                rec_mode = lfr_pkg::MODE_FOLLOW;
                res.dir = lfr_pkg::DIR_RIGHT;
                res.duty_a = cfg_slight;
                res.duty_b = cfg_slight;
            end
            default:
            begin
                if (rec_mode == lfr_pkg::MODE_FOLLOW)
                begin
                    rec_mode = lfr_pkg::MODE_RIGHT;
                    rec_start = s.now_ticks;
                    rec_pairs = '0;
                end
                elapsed = s.now_ticks - rec_start;
                case (rec_mode)
                    lfr_pkg::MODE_RIGHT:
                    begin
                        res.dir = lfr_pkg::DIR_RIGHT;
                        res.duty_b = cfg_search;
                        if (elapsed >= {16'd0, cfg_sweep_ticks})
                        begin
                            rec_mode = lfr_pkg::MODE_LEFT;
                            rec_start = s.now_ticks;
                        end
                    end
                    lfr_pkg::MODE_LEFT:
                    begin
                        res.dir = lfr_pkg::DIR_LEFT;
                        res.duty_a = cfg_search;
                        if (elapsed >= {16'd0, cfg_sweep_ticks})
                        begin
                            rec_pairs = rec_pairs + 4'd1;
                            rec_mode = (rec_pairs < cfg_max_sweeps) ?
                                       lfr_pkg::MODE_RIGHT : lfr_pkg::MODE_REVERSE;
                            rec_start = s.now_ticks;
                        end
                    end
                    default:
                    begin
                        res.dir = lfr_pkg::DIR_BACKWARD;
                        res.duty_a = cfg_search;
                        res.duty_b = cfg_search;
                        // window over: stop, but the phase start is kept
                        if (elapsed >= {16'd0, cfg_reverse_ticks})
                            res.dir = lfr_pkg::DIR_STOP;
                    end
                endcase
            end
        endcase
        res.phase = rec_mode;
        return res;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0)
        begin
            calm = $urandom_range(40, 200);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // sensor beat driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (src_wait > 0)
            begin
                src_wait <= src_wait - 1;
                s_tvalid <= 1'b0;
            end
            else if (sample_q.size() != 0)
            begin
                s_tdata <= {5'd0, sample_q.pop_front()};
                s_tvalid <= 1'b1;
                src_wait <= pick_gap(src_calm);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result sink with random stalls and one long hold-off
    always @(posedge clk)
    begin : sink
        int g;
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (snk_wait > 0)
        begin
            snk_wait <= snk_wait - 1;
            m_tready <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            g = pick_gap(snk_calm);
            m_tready <= (g == 0);
            snk_wait <= (g > 0) ? g - 1 : 0;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: check result beats, then predict for the accepted sensor beat
    always @(posedge clk)
    begin : monitor
        lfr_drive_t want;
        lfr_drive_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[20:0];
                if (drive_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = drive_q.pop_front();
                    check_field("drive_dir", want.dir, got.dir);
                    check_field("duty_a", want.duty_a, got.duty_a);
                    check_field("duty_b", want.duty_b, got.duty_b);
                    check_field("recovery_phase", want.phase, got.phase);
                end
            end
            if (s_tvalid && s_tready)
                drive_q.push_back(next_drive(s_tdata[34:0]));
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL line_follower_recovery_fsm");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            lfr_pkg::REG_BASE_SPEED_A:      cfg_base_a = val[7:0];
            lfr_pkg::REG_BASE_SPEED_B:      cfg_base_b = val[7:0];
            lfr_pkg::REG_TURN_SPEED:        cfg_turn = val[7:0];
            lfr_pkg::REG_SLIGHT_TURN_SPEED: cfg_slight = val[7:0];
            lfr_pkg::REG_SEARCH_SPEED:      cfg_search = val[7:0];
            lfr_pkg::REG_SWEEP_TICKS:       cfg_sweep_ticks = val[15:0];
            lfr_pkg::REG_REVERSE_TICKS:     cfg_reverse_ticks = val[15:0];
            lfr_pkg::REG_MAX_SWEEPS:        cfg_max_sweeps = val[3:0];
            default:                        ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] base_a, input logic [7:0] base_b,
                              input logic [7:0] turn, input logic [7:0] slight,
                              input logic [7:0] search, input logic [15:0] sweep,
                              input logic [15:0] reverse, input logic [3:0] pairs);
        cfg_write(lfr_pkg::REG_BASE_SPEED_A, {24'd0, base_a});
        cfg_write(lfr_pkg::REG_BASE_SPEED_B, {24'd0, base_b});
        cfg_write(lfr_pkg::REG_TURN_SPEED, {24'd0, turn});
        cfg_write(lfr_pkg::REG_SLIGHT_TURN_SPEED, {24'd0, slight});
        cfg_write(lfr_pkg::REG_SEARCH_SPEED, {24'd0, search});
        cfg_write(lfr_pkg::REG_SWEEP_TICKS, {16'd0, sweep});
        cfg_write(lfr_pkg::REG_REVERSE_TICKS, {16'd0, reverse});
        cfg_write(lfr_pkg::REG_MAX_SWEEPS, {28'd0, pairs});
    endtask

    // block idle: nothing queued, offered or in flight
    task automatic wait_idle();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || s_tvalid || drive_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_sample(input logic [2:0] pat, input logic [31:0] t);
        lfr_sample_t s;
        s.sense_left = pat[2];
        s.sense_center = pat[1];
        s.sense_right = pat[0];
        s.now_ticks = t;
        sample_q.push_back(s);
    endtask

    function automatic logic [31:0] tick_step();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(0, cfg_sweep_ticks / 2 + 1);
        if (r < 9)
            return $urandom_range(0, cfg_reverse_ticks / 3 + 1);
        return $urandom_range(0, 3);
    endfunction

    // line losses with advancing ticks, short follow stretches and raw noise
    task automatic run_random(input int unsigned count);
        int unsigned queued;
        int unsigned len;
        int          r;
        logic [2:0]  pat;
        queued = 0;
        while (queued < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                len = $urandom_range(3, 12 * cfg_max_sweeps + 12);
                for (int k = 0; k < len; k++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 9)
                    begin
                        case ($urandom_range(0, 2))
                            0:       pat = lfr_pkg::PAT_C;
                            1:       pat = lfr_pkg::PAT_ALL;
                            default: pat = lfr_pkg::PAT_LR;
                        endcase
                    end
                    else if (r < 12)
                        pat = 3'($urandom_range(1, 7));
                    else
                        pat = lfr_pkg::PAT_NONE;
                    tick_now = tick_now + tick_step();
                    push_sample(pat, tick_now);
                end
                queued += len;
            end
            else if (r < 95)
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                begin
                    tick_now = tick_now + $urandom_range(0, 20);
                    push_sample(3'($urandom_range(1, 7)), tick_now);
                end
                queued += len;
            end
            else
            begin
                tick_now = $urandom();
                push_sample(3'($urandom_range(0, 7)), tick_now);
                queued += 1;
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // every pattern but PAT_NONE under the reset settings
        push_sample(lfr_pkg::PAT_C, 32'd10);
        push_sample(lfr_pkg::PAT_ALL, 32'd11);
        push_sample(lfr_pkg::PAT_LR, 32'd12);
        push_sample(lfr_pkg::PAT_L, 32'd13);
        push_sample(lfr_pkg::PAT_LC, 32'd14);
        push_sample(lfr_pkg::PAT_R, 32'd15);
        push_sample(lfr_pkg::PAT_CR, 32'd16);
        // full recovery: three sweep pairs, reverse, then stop
        push_sample(lfr_pkg::PAT_NONE, 32'd1000);
        push_sample(lfr_pkg::PAT_NONE, 32'd1149);
        push_sample(lfr_pkg::PAT_C, 32'd1150);
        push_sample(lfr_pkg::PAT_NONE, 32'd1150);
        push_sample(lfr_pkg::PAT_LR, 32'd1200);
        push_sample(lfr_pkg::PAT_NONE, 32'd1300);
        push_sample(lfr_pkg::PAT_NONE, 32'd1450);
        push_sample(lfr_pkg::PAT_NONE, 32'd1600);
        push_sample(lfr_pkg::PAT_NONE, 32'd1750);
        push_sample(lfr_pkg::PAT_NONE, 32'd1900);
        push_sample(lfr_pkg::PAT_NONE, 32'd2000);
        push_sample(lfr_pkg::PAT_ALL, 32'd3000);
        push_sample(lfr_pkg::PAT_NONE, 32'd4399);
        push_sample(lfr_pkg::PAT_NONE, 32'd4400);
        push_sample(lfr_pkg::PAT_NONE, 32'd4500);
        // sweep window across the tick wrap
        push_sample(lfr_pkg::PAT_R, 32'd4501);
        push_sample(lfr_pkg::PAT_NONE, 32'hFFFF_FFC0);
        push_sample(lfr_pkg::PAT_NONE, 32'h0000_0056);
        push_sample(lfr_pkg::PAT_CR, 32'h0000_0060);
        wait_idle();

        // zero windows: each phase ends in the step it is entered
        set_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 4'd1);
        tick_now = 32'd5000;
        push_sample(lfr_pkg::PAT_NONE, tick_now);
        push_sample(lfr_pkg::PAT_NONE, tick_now);
        push_sample(lfr_pkg::PAT_NONE, tick_now);
        push_sample(lfr_pkg::PAT_C, tick_now);
        run_random(PHASE_ITEMS);
        hold_go <= 1'b1;
        wait_idle();

        set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 4'd15);
        tick_now = 32'hFFFF_0000;
        push_sample(lfr_pkg::PAT_C, tick_now);
        push_sample(lfr_pkg::PAT_L, tick_now);
        push_sample(lfr_pkg::PAT_LR, tick_now);
        run_random(PHASE_ITEMS);
        wait_idle();

        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 16'($urandom_range(1, 40)),
                   16'($urandom_range(5, 200)), 4'($urandom_range(1, 4)));
        tick_now = $urandom();
        run_random(PHASE_ITEMS);
        wait_idle();

        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 16'($urandom_range(0, 8)),
                   16'($urandom_range(0, 30)), 4'($urandom_range(1, 15)));
        tick_now = $urandom();
        run_random(PHASE_ITEMS);
        wait_idle();
        repeat (6) @(posedge clk);

        if (errors == 0)
            $display("PASS line_follower_recovery_fsm");
        else
            $display("FAIL line_follower_recovery_fsm");
        $finish;
    end

endmodule
